/* sv/erm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm_pkg
// Shared constants, types and state codes of the echo range median filter.
// ----------------------------------------------------------------------------
package erm_pkg;

  localparam int MAX_SAMPLES = 8;
  localparam int IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

  localparam int TS_W    = 32;
  localparam int DUR_W   = 16;
  localparam int X_W     = DUR_W + 3;
  localparam int DIST_W  = 15;
  localparam int COUNT_W = 4;
  localparam int WIN_CFG_W = 4;

  // Distance is duration * 8 / 29; the division is a reciprocal multiply.
  localparam int DIVISOR     = 29;
  localparam int RECIP_SHIFT = 25;
  localparam int M_W         = 21;
  localparam logic [M_W-1:0] RECIP_MULT = M_W'((64'd1 << RECIP_SHIFT) / DIVISOR);
  localparam int PROD_W      = X_W + M_W;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_SIZE = '0;

  localparam logic [CNT_W-1:0] WINDOW_RESET =
    CNT_W'((MAX_SAMPLES < 8) ? MAX_SAMPLES : 8);

  typedef logic [MAX_SAMPLES-1:0][DIST_W-1:0] sample_arr_t;

  typedef struct packed {
    logic              ok;
    logic [DIST_W-1:0] value;
  } dist_t;

  typedef struct packed {
    logic [CNT_W-1:0] less;
    logic [CNT_W-1:0] leq;
  } rank_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

/* sv/erm_distance.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm_distance
// Echo duration to distance in cm with four fraction bits, via a register.
// ----------------------------------------------------------------------------
module erm_distance (
  input  logic                     clk,
  input  logic                     load,
  input  logic                     echo_ready,
  input  logic [erm_pkg::TS_W-1:0] rise_time_us,
  input  logic [erm_pkg::TS_W-1:0] fall_time_us,
  output erm_pkg::dist_t           conv
);
  import erm_pkg::*;

  logic [TS_W-1:0]   dur;
  logic [DUR_W-1:0]  dur_sat;
  logic [X_W-1:0]    x;
  logic [PROD_W-1:0] prod_r;
  logic [X_W-1:0]    x_r;
  logic              ok_r;
  logic [DIST_W-1:0] q0;
  logic [X_W-1:0]    rem;

  always_comb begin
    dur     = fall_time_us - rise_time_us;
    dur_sat = (dur > TS_W'({DUR_W{1'b1}})) ? {DUR_W{1'b1}} : dur[DUR_W-1:0];
    x       = {dur_sat, 3'b000};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= PROD_W'(x) * PROD_W'(RECIP_MULT);
      x_r    <= x;
      ok_r   <= echo_ready && (dur_sat != '0);
    end
  end

  // The reciprocal is rounded down, so the estimate is exact or one short.
  always_comb begin
    q0         = prod_r[RECIP_SHIFT +: DIST_W];
    rem        = x_r - X_W'(q0) * X_W'(DIVISOR);
    conv.ok    = ok_r;
    conv.value = (rem >= X_W'(DIVISOR)) ? q0 + 1'b1 : q0;
  end

endmodule

/* sv/erm_rank_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm_rank_unit
// Counts the valid samples below and not above one candidate value.
// ----------------------------------------------------------------------------
module erm_rank_unit (
  input  logic [erm_pkg::DIST_W-1:0]      cand,
  input  erm_pkg::sample_arr_t            samples,
  input  logic [erm_pkg::MAX_SAMPLES-1:0] marks,
  output erm_pkg::rank_t                  rank
);
  import erm_pkg::*;

  always_comb begin
    rank.less = '0;
    rank.leq  = '0;
    for (int i = 0; i < MAX_SAMPLES; i++) begin
      rank.less = rank.less + CNT_W'(marks[i] && (samples[i] < cand));
      rank.leq  = rank.leq + CNT_W'(marks[i] && (samples[i] <= cand));
    end
  end

endmodule

/* sv/echo_range_median_filter_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_range_median_filter_core
// Running median of echo ranging distances over a window of recent beats.
//
// An input beat carries the echo flag and the rise and fall timestamps.
// It is converted to a distance and written over the oldest slot of the
// ring; a valid-marked slot holds a sample, an invalid beat clears it.
// One output beat follows each input beat: the median distance, its valid
// flag and the number of valid samples in the window.
// The input takes a beat only in the idle state. The conversion is
// registered as the beat is accepted, the ring is written in the write
// state, and the median search visits every slot with the shared rank
// unit, one slot a cycle, then the done state loads the output register.
// A new beat is taken only once that load has returned the block to idle.
// The output register holds its beat while out_stall is high; the next
// search then waits in its final state until the register is free.
// Synchronous reset empties the window, sets the window size to eight and
// the write slot to zero. Writing window_size over the APB port does the
// same with the new size, clamped to one through MAX_SAMPLES.
// ----------------------------------------------------------------------------
module echo_range_median_filter_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_echo_ready,
  input  logic [erm_pkg::TS_W-1:0]       in_rise_time_us,
  input  logic [erm_pkg::TS_W-1:0]       in_fall_time_us,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [erm_pkg::DIST_W-1:0]     out_median_cm_q4,
  output logic                           out_median_valid,
  output logic [erm_pkg::COUNT_W-1:0]    out_valid_count,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [erm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [erm_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [erm_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import erm_pkg::*;

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       window_r, window_nxt;
  logic [IDX_W-1:0]       slot_r, slot_nxt;
  logic [IDX_W-1:0]       cand_r, cand_nxt;
  logic [MAX_SAMPLES-1:0] marks_r, marks_nxt;
  sample_arr_t            store_r, store_nxt;
  logic [DIST_W-1:0]      med_r, med_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0]      out_med_r, out_med_nxt;
  logic                   out_mvalid_r, out_mvalid_nxt;
  logic [COUNT_W-1:0]     out_count_r, out_count_nxt;

  logic                   accept;
  logic                   cfg_write;
  logic [WIN_CFG_W-1:0]   cfg_win;
  logic [CNT_W-1:0]       cfg_win_clamped;
  logic [IDX_W-1:0]       wslot;
  logic [CNT_W-1:0]       wslot_inc;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       mid;
  dist_t                  conv;
  rank_t                  rank;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr == REG_WINDOW_SIZE);
  assign cfg_win   = pwdata[WIN_CFG_W-1:0];
  assign prdata    = (paddr == REG_WINDOW_SIZE) ? CFG_DATA_W'(window_r) : '0;

  assign out_valid        = out_valid_r;
  assign out_median_cm_q4 = out_med_r;
  assign out_median_valid = out_mvalid_r;
  assign out_valid_count  = out_count_r;

  always_comb begin
    if (cfg_win == '0) begin
      cfg_win_clamped = CNT_W'(1);
    end else if (int'(cfg_win) > MAX_SAMPLES) begin
      cfg_win_clamped = CNT_W'(MAX_SAMPLES);
    end else begin
      cfg_win_clamped = CNT_W'(cfg_win);
    end
  end

  erm_distance u_distance (
    .clk          (clk),
    .load         (accept),
    .echo_ready   (in_echo_ready),
    .rise_time_us (in_rise_time_us),
    .fall_time_us (in_fall_time_us),
    .conv         (conv)
  );

  erm_rank_unit u_rank (
    .cand    (store_r[cand_r]),
    .samples (store_r),
    .marks   (marks_r),
    .rank    (rank)
  );

  always_comb begin
    count = '0;
    for (int i = 0; i < MAX_SAMPLES; i++) begin
      count = count + CNT_W'(marks_r[i]);
    end
    mid = count >> 1;
  end

  always_comb begin
    wslot     = (CNT_W'(slot_r) >= window_r) ? '0 : slot_r;
    wslot_inc = CNT_W'(wslot) + 1'b1;
  end

  always_comb begin
    state_nxt      = state_r;
    window_nxt     = window_r;
    slot_nxt       = slot_r;
    cand_nxt       = cand_r;
    marks_nxt      = marks_r;
    store_nxt      = store_r;
    med_nxt        = med_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_med_nxt    = out_med_r;
    out_mvalid_nxt = out_mvalid_r;
    out_count_nxt  = out_count_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        marks_nxt[wslot] = conv.ok;
        if (conv.ok) begin
          store_nxt[wslot] = conv.value;
        end
        slot_nxt  = (wslot_inc == window_r) ? '0 : IDX_W'(wslot_inc);
        cand_nxt  = '0;
        med_nxt   = '0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (marks_r[cand_r] && (rank.less <= mid) && (mid < rank.leq)) begin
          med_nxt = store_r[cand_r];
        end
        if (cand_r == IDX_W'(MAX_SAMPLES - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          cand_nxt = cand_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_med_nxt    = med_r;
          out_mvalid_nxt = (count != '0);
          out_count_nxt  = COUNT_W'(count);
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_write) begin
      window_nxt = cfg_win_clamped;
      marks_nxt  = '0;
      slot_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      window_r    <= WINDOW_RESET;
      slot_r      <= '0;
      cand_r      <= '0;
      marks_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      window_r    <= window_nxt;
      slot_r      <= slot_nxt;
      cand_r      <= cand_nxt;
      marks_r     <= marks_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    store_r      <= store_nxt;
    med_r        <= med_nxt;
    out_med_r    <= out_med_nxt;
    out_mvalid_r <= out_mvalid_nxt;
    out_count_r  <= out_count_nxt;
  end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the echo range running median filter.
//
// Echo beats go in over the valid/stall input channel in random bursts. At
// acceptance, a local model of the sample ring works out the distance, the
// median of the valid samples and their count. The expected beats are held
// in order and compared field by field with each output beat, while the
// output side stalls in changing patterns. The window size is rewritten
// over the APB port between traffic segments, only when no beat is in
// flight. The phases are directed corner beats, every window setting, and
// long random traffic.
// ----------------------------------------------------------------------------
module tb_top;

  import erm_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = MAX_SAMPLES + 8;
  localparam int RANDOM_ITEMS = 1650;
  localparam int PRINT_LIMIT  = 20;

  typedef struct packed {
    logic [DIST_W-1:0]  median;
    logic               ok;
    logic [COUNT_W-1:0] count;
  } median_beat_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_COIN,
    STALL_HEAVY
  } stall_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_echo_ready = 1'b0;
  logic [TS_W-1:0]       in_rise_time_us = '0;
  logic [TS_W-1:0]       in_fall_time_us = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [DIST_W-1:0]     out_median_cm_q4;
  logic                  out_median_valid;
  logic [COUNT_W-1:0]    out_valid_count;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  logic [DIST_W-1:0] ring_dist [MAX_SAMPLES];
  logic              ring_mark [MAX_SAMPLES];
  int unsigned       ring_slot;
  int unsigned       ring_len;
  median_beat_t      median_q[$];

  int          fail_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          stall_left = 0;
  stall_mode_t stall_mode = STALL_NONE;

  echo_range_median_filter_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_echo_ready    (in_echo_ready),
    .in_rise_time_us  (in_rise_time_us),
    .in_fall_time_us  (in_fall_time_us),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_median_cm_q4 (out_median_cm_q4),
    .out_median_valid (out_median_valid),
    .out_valid_count  (out_valid_count),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (fail_count < PRINT_LIMIT) begin
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    end
    fail_count++;
  endtask

  task automatic reset_ring(input int unsigned len);
    ring_len = len;
    ring_slot = 0;
    for (int i = 0; i < MAX_SAMPLES; i++) begin
      ring_mark[i] = 1'b0;
    end
  endtask

  task automatic predict_median(input logic rdy, input logic [TS_W-1:0] rise,
                                input logic [TS_W-1:0] fall);
    logic [31:0]       dur;
    int unsigned       slot;
    int unsigned       n;
    int unsigned       j;
    logic [DIST_W-1:0] sorted [MAX_SAMPLES];
    median_beat_t      beat;
    dur = fall - rise;
    if (dur > 32'd65535) begin
      dur = 32'd65535;
    end
    slot = ring_slot;
    if (slot >= ring_len) begin
      slot = 0;
    end
    if (rdy && dur != 0) begin
      ring_dist[slot] = DIST_W'((dur * 32'd16) / 32'd58);
      ring_mark[slot] = 1'b1;
    end else begin
      ring_mark[slot] = 1'b0;
    end
    ring_slot = (slot + 1) % ring_len;
    n = 0;
    for (int unsigned i = 0; i < ring_len; i++) begin
      if (ring_mark[i]) begin
        j = n;
        while (j > 0 && sorted[j-1] > ring_dist[i]) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = ring_dist[i];
        n++;
      end
    end
    beat.count = COUNT_W'(n);
    beat.ok = (n != 0);
    beat.median = (n != 0) ? sorted[n/2] : '0;
    median_q.push_back(beat);
  endtask

  always @(posedge clk) begin : check_results
    median_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (median_q.size() == 0) begin
        report_mismatch("unexpected output beat", 1, 0);
      end else begin
        want = median_q.pop_front();
        if (out_median_cm_q4 !== want.median) begin
          report_mismatch("median_cm_q4", out_median_cm_q4, want.median);
        end
        if (out_median_valid !== want.ok) begin
          report_mismatch("median_valid", out_median_valid, want.ok);
        end
        if (out_valid_count !== want.count) begin
          report_mismatch("valid_count", out_valid_count, want.count);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_left <= $urandom_range(20, 200);
      stall_mode <= stall_mode_t'($urandom_range(0, 2));
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE: begin
        out_stall <= 1'b0;
      end
      STALL_COIN: begin
        out_stall <= ($urandom_range(0, 1) == 1);
      end
      default: begin
        out_stall <= ($urandom_range(0, 7) != 0);
      end
    endcase
  end

  task automatic send_echo(input logic rdy, input logic [TS_W-1:0] rise,
                           input logic [TS_W-1:0] fall);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_echo_ready <= rdy;
    in_rise_time_us <= rise;
    in_fall_time_us <= fall;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_median(rdy, rise, fall);
  endtask

  task automatic send_random_echo();
    logic            rdy;
    logic [TS_W-1:0] rise;
    logic [TS_W-1:0] fall;
    int              kind;
    kind = $urandom_range(0, 15);
    rdy = 1'b1;
    rise = $urandom;
    if (kind < 2) begin
      rdy = 1'b0;
      fall = $urandom;
    end else if (kind == 2) begin
      fall = rise;
    end else if (kind == 3) begin
      fall = $urandom;
    end else if (kind == 4) begin
      fall = rise + TS_W'($urandom_range(65536, 400000));
    end else if (kind < 8) begin
      fall = rise + TS_W'($urandom_range(1, 255));
    end else begin
      fall = rise + TS_W'($urandom_range(1, 65535));
    end
    send_echo(rdy, rise, fall);
  endtask

  task automatic settle_idle();
    in_valid <= 1'b0;
    while (median_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_window_size(input logic [CFG_DATA_W-1:0] value);
    int unsigned len;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_WINDOW_SIZE;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    len = value[3:0];
    if (len < 1) begin
      len = 1;
    end else if (len > MAX_SAMPLES) begin
      len = MAX_SAMPLES;
    end
    reset_ring(len);
  endtask

  task automatic test_directed_echoes();
    send_echo(1'b0, 32'd0, 32'd100);
    send_echo(1'b1, 32'h1234_5678, 32'h1234_5678);
    send_echo(1'b1, 32'd0, 32'd1);
    send_echo(1'b1, 32'd0, 32'd4);
    send_echo(1'b1, 32'd1000, 32'd1058);
    send_echo(1'b1, 32'd0, 32'd65535);
    send_echo(1'b1, 32'd0, 32'd65536);
    send_echo(1'b1, 32'd0, 32'hFFFF_FFFF);
    send_echo(1'b1, 32'hFFFF_FFFF, 32'd0);
    send_echo(1'b1, 32'hFFFF_FFF0, 32'h0000_0100);
    send_echo(1'b1, 32'h8000_0000, 32'h8000_16A8);
    send_echo(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_echo(1'b0, 32'd0, 32'd0);
    send_echo(1'b1, 32'h5555_5555, 32'hAAAA_AAAA);
    send_echo(1'b1, 32'hAAAA_AAAA, 32'hAAAA_AB00);
    settle_idle();
    write_window_size(32'd1);
    send_echo(1'b1, 32'd10, 32'd300);
    send_echo(1'b0, 32'd10, 32'd300);
    send_echo(1'b1, 32'd0, 32'd70000);
    send_echo(1'b1, 32'd7, 32'd7);
    settle_idle();
  endtask

  task automatic test_window_settings();
    logic [CFG_DATA_W-1:0] sizes [10];
    sizes = '{32'd8, 32'd0, 32'd15, 32'd9, 32'd2, 32'd5, 32'd7, 32'd3, 32'd6, 32'd4};
    foreach (sizes[k]) begin
      write_window_size(sizes[k]);
      repeat (30) send_random_echo();
      settle_idle();
    end
  endtask

  task automatic test_random_traffic();
    int sent;
    int seg;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      write_window_size($urandom);
      seg = $urandom_range(50, 250);
      repeat (seg) send_random_echo();
      sent += seg;
      settle_idle();
    end
  endtask

  initial begin
    reset_ring(MAX_SAMPLES);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_echoes();
    test_window_settings();
    test_random_traffic();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
